@@ hdl/ntp_reply_check_and_clock_unit_macros.svh @@
// ----------------------------------------------------------------------------
// NTP reply check and clock unit - assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NTP_REPLY_CHECK_AND_CLOCK_UNIT_MACROS_SVH
`define NTP_REPLY_CHECK_AND_CLOCK_UNIT_MACROS_SVH

`ifndef SYNTH
`define NTPRC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define NTPRC_ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define NTPRC_ASSERT(name, clk, rst_n, prop)
`define NTPRC_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

@@ hdl/ntprc_pkg.sv @@
// ----------------------------------------------------------------------------
// ntprc_pkg
// Shared types and constants for the NTP reply check and clock unit.
// ----------------------------------------------------------------------------
package ntprc_pkg;

    localparam int unsigned TZ_W   = 18;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned MS_W   = 10;
    localparam int unsigned OUT_W  = 136;

    localparam logic [31:0]      NTP_UNIX_OFFSET = 32'd2208988800;
    localparam logic [POS_W-1:0] MIN_REPLY_LEN   = 6'd48;
    localparam logic [POS_W-1:0] TX_SEC_POS      = 6'd40;
    localparam logic [POS_W-1:0] TX_FRAC_POS     = 6'd44;
    localparam logic [POS_W-1:0] POS_LIMIT       = 6'd63;
    localparam logic [POS_W-1:0] POS_HEADER      = 6'd0;
    localparam logic [POS_W-1:0] POS_STRATUM     = 6'd1;
    localparam logic [MS_W-1:0]  MS_PER_SEC      = 10'd1000;
    localparam logic [MS_W-1:0]  MS_LAST         = 10'd999;

    localparam logic [2:0] MODE_SERVER    = 3'd4;
    localparam logic [2:0] MODE_BROADCAST = 3'd5;
    localparam logic [1:0] LI_ALARM       = 2'd3;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_BAD_MODE     = 3'd2,
        ST_UNSYNC       = 3'd3,
        ST_STRATUM_ZERO = 3'd4,
        ST_ZERO_SECONDS = 3'd5
    } status_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       end_of_packet;
    } item_t;

    typedef struct packed {
        logic [31:0] stamp_fraction;
        logic [31:0] stamp_seconds;
        logic [31:0] local_seconds;
        logic [31:0] unix_seconds;
        logic        is_synced;
        status_t     reply_status;
        logic        reply_done;
    } result_t;

endpackage

@@ hdl/ntprc_in_stage.sv @@
// ----------------------------------------------------------------------------
// ntprc_in_stage
// Input register: holds one item until the core takes it.
// ----------------------------------------------------------------------------
module ntprc_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ntprc_pkg::item_t in_item,
    output logic            item_valid,
    output ntprc_pkg::item_t item,
    input  logic            item_take
);

    logic             valid_reg;
    logic             valid_next;
    ntprc_pkg::item_t item_reg;
    logic             load;

    assign in_ready   = !valid_reg || item_take;
    assign load       = in_valid && in_ready;
    assign valid_next = load ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/ntprc_core.sv @@
// ----------------------------------------------------------------------------
// ntprc_core
// Reply parsing, checks, held time, running clock and result register.
// ----------------------------------------------------------------------------
`include "ntp_reply_check_and_clock_unit_macros.svh"

module ntprc_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [ntprc_pkg::TZ_W-1:0]     cfg_wr_data,
    input  logic                           item_valid,
    input  ntprc_pkg::item_t               item,
    output logic                           item_take,
    output logic                           res_valid,
    output ntprc_pkg::result_t             res,
    input  logic                           res_ready
);

    logic [ntprc_pkg::TZ_W-1:0]  tz_reg;
    logic [ntprc_pkg::POS_W-1:0] pos_reg,   pos_next;
    logic [7:0]                  hdr_reg,   hdr_next;
    logic [7:0]                  strat_reg, strat_next;
    logic [31:0]                 psec_reg,  psec_next;
    logic [31:0]                 pfrac_reg, pfrac_next;
    logic                        sync_reg,  sync_next;
    logic [31:0]                 hsec_reg,  hsec_next;
    logic [31:0]                 hfrac_reg, hfrac_next;
    logic                        base_ok_reg, base_ok_next;
    logic [31:0]                 unix_cur_reg, unix_cur_next;
    logic [ntprc_pkg::MS_W-1:0]  ms_reg,    ms_next;
    logic                        out_valid_reg, out_valid_next;
    ntprc_pkg::result_t          out_reg,   out_next;

    logic [ntprc_pkg::POS_W-1:0] pos_a;
    logic [7:0]                  hdr_a;
    logic [7:0]                  strat_a;
    logic [31:0]                 psec_a;
    logic [31:0]                 pfrac_a;
    ntprc_pkg::status_t          status;
    logic                        done;
    logic [31:0]                 unix_val;
    logic [31:0]                 tz_ext;

    assign item_take      = item_valid && (!out_valid_reg || res_ready);
    assign out_valid_next = item_take ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    assign tz_ext = {{(32 - ntprc_pkg::TZ_W){tz_reg[ntprc_pkg::TZ_W-1]}}, tz_reg};

    // byte capture as seen after this item
    always_comb
    begin
        hdr_a   = hdr_reg;
        strat_a = strat_reg;
        psec_a  = psec_reg;
        pfrac_a = pfrac_reg;
        pos_a   = pos_reg;
        if (pos_reg == ntprc_pkg::POS_HEADER)
        begin
            hdr_a = item.data_byte;
        end
        else if (pos_reg == ntprc_pkg::POS_STRATUM)
        begin
            strat_a = item.data_byte;
        end
        else if (pos_reg >= ntprc_pkg::TX_SEC_POS && pos_reg < ntprc_pkg::TX_FRAC_POS)
        begin
            psec_a = {psec_reg[23:0], item.data_byte};
        end
        else if (pos_reg >= ntprc_pkg::TX_FRAC_POS && pos_reg < ntprc_pkg::MIN_REPLY_LEN)
        begin
            pfrac_a = {pfrac_reg[23:0], item.data_byte};
        end
        if (pos_reg < ntprc_pkg::POS_LIMIT)
        begin
            pos_a = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (pos_a < ntprc_pkg::MIN_REPLY_LEN)
        begin
            status = ntprc_pkg::ST_SHORT;
        end
        else if (!(hdr_a[2:0] inside {ntprc_pkg::MODE_SERVER, ntprc_pkg::MODE_BROADCAST}))
        begin
            status = ntprc_pkg::ST_BAD_MODE;
        end
        else if (hdr_a[7:6] == ntprc_pkg::LI_ALARM)
        begin
            status = ntprc_pkg::ST_UNSYNC;
        end
        else if (strat_a == 8'd0)
        begin
            status = ntprc_pkg::ST_STRATUM_ZERO;
        end
        else if (psec_a == 32'd0)
        begin
            status = ntprc_pkg::ST_ZERO_SECONDS;
        end
        else
        begin
            status = ntprc_pkg::ST_OK;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        hdr_next      = hdr_reg;
        strat_next    = strat_reg;
        psec_next     = psec_reg;
        pfrac_next    = pfrac_reg;
        sync_next     = sync_reg;
        hsec_next     = hsec_reg;
        hfrac_next    = hfrac_reg;
        base_ok_next  = base_ok_reg;
        unix_cur_next = unix_cur_reg;
        ms_next       = ms_reg;
        done          = 1'b0;
        out_next      = out_reg;
        if (item.action == ntprc_pkg::ACT_TICK)
        begin
            if (ms_reg >= ntprc_pkg::MS_LAST)
            begin
                ms_next       = '0;
                unix_cur_next = unix_cur_reg + 32'd1;
            end
            else
            begin
                ms_next = ms_reg + 1'b1;
            end
        end
        else if (item.end_of_packet)
        begin
            done       = 1'b1;
            pos_next   = '0;
            hdr_next   = '0;
            strat_next = '0;
            psec_next  = '0;
            pfrac_next = '0;
            if (status == ntprc_pkg::ST_OK)
            begin
                sync_next     = 1'b1;
                hsec_next     = psec_a;
                hfrac_next    = pfrac_a;
                base_ok_next  = psec_a >= ntprc_pkg::NTP_UNIX_OFFSET;
                unix_cur_next = psec_a - ntprc_pkg::NTP_UNIX_OFFSET;
                ms_next       = '0;
            end
        end
        else
        begin
            pos_next   = pos_a;
            hdr_next   = hdr_a;
            strat_next = strat_a;
            psec_next  = psec_a;
            pfrac_next = pfrac_a;
        end

        unix_val = (sync_next && base_ok_next) ? unix_cur_next : 32'd0;

        out_next.reply_done     = done;
        out_next.reply_status   = done ? status : ntprc_pkg::ST_OK;
        out_next.is_synced      = sync_next;
        out_next.unix_seconds   = unix_val;
        out_next.local_seconds  = (unix_val == 32'd0) ? 32'd0 : unix_val + tz_ext;
        out_next.stamp_seconds  = hsec_next;
        out_next.stamp_fraction = hfrac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_reg        <= '0;
            pos_reg       <= '0;
            hdr_reg       <= '0;
            strat_reg     <= '0;
            psec_reg      <= '0;
            pfrac_reg     <= '0;
            sync_reg      <= 1'b0;
            hsec_reg      <= '0;
            hfrac_reg     <= '0;
            base_ok_reg   <= 1'b0;
            unix_cur_reg  <= '0;
            ms_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tz_reg <= cfg_wr_data;
            end
            if (item_take)
            begin
                pos_reg      <= pos_next;
                hdr_reg      <= hdr_next;
                strat_reg    <= strat_next;
                psec_reg     <= psec_next;
                pfrac_reg    <= pfrac_next;
                sync_reg     <= sync_next;
                hsec_reg     <= hsec_next;
                hfrac_reg    <= hfrac_next;
                base_ok_reg  <= base_ok_next;
                unix_cur_reg <= unix_cur_next;
                ms_reg       <= ms_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `NTPRC_ASSERT_NEVER(a_ms_range, clk, rst_n, ms_reg >= ntprc_pkg::MS_PER_SEC)
    `NTPRC_ASSERT(a_sync_sticky, clk, rst_n, sync_reg |=> sync_reg)
    `NTPRC_ASSERT_NEVER(a_local_zero, clk, rst_n, out_valid_reg && out_reg.unix_seconds == 32'd0 && out_reg.local_seconds != 32'd0)
    `NTPRC_ASSERT_NEVER(a_status_idle, clk, rst_n, out_valid_reg && !out_reg.reply_done && out_reg.reply_status != ntprc_pkg::ST_OK)

endmodule

@@ hdl/ntp_reply_check_and_clock_unit.sv @@
// ----------------------------------------------------------------------------
// ntp_reply_check_and_clock_unit
// Checks NTP reply payloads byte by byte and keeps a running Unix clock.
//
// Channel   Dir  Handshake                 Content
// s_axis    in   s_axis_tvalid/tready      tdata: data_byte; tlast: end_of_packet;
//                                          tuser: action (1 = ms tick)
// m_axis    out  m_axis_tvalid/tready      tdata: one result item
// cfg       in   cfg_wr_en                 cfg_wr_data: timezone_offset
//
// One item per cycle sustained while m_axis_tready does not stall the result.
// Each item passes the input register and the result register; every item
// gives exactly one result item.
// Reset (rst_n, asynchronous) clears the held time, the clock and the offset.
// A stalled result holds one item; the input register takes one more.
// ----------------------------------------------------------------------------
module ntp_reply_check_and_clock_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  logic                        s_axis_tlast,
    input  logic [0:0]                  s_axis_tuser,   // [0] action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] reply_done, [3:1] reply_status, [4] is_synced, [36:5] unix_seconds,
    // [68:37] local_seconds, [100:69] stamp_seconds, [132:101] stamp_fraction,
    // [135:133] zero
    output logic [ntprc_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                        cfg_wr_en,
    input  logic [ntprc_pkg::TZ_W-1:0]  cfg_wr_data
);

    ntprc_pkg::item_t   in_item;
    ntprc_pkg::item_t   item;
    logic               item_valid;
    logic               item_take;
    ntprc_pkg::result_t res;

    assign in_item.action        = s_axis_tuser[0];
    assign in_item.data_byte     = s_axis_tdata;
    assign in_item.end_of_packet = s_axis_tlast;

    ntprc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    ntprc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .res_valid   (m_axis_tvalid),
        .res         (res),
        .res_ready   (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000,
                           res.stamp_fraction,
                           res.stamp_seconds,
                           res.local_seconds,
                           res.unix_seconds,
                           res.is_synced,
                           res.reply_status,
                           res.reply_done};

endmodule
